### design/msq_pkg.sv
package msq_pkg;

  // register and field widths
  localparam int CFG_W  = 11;
  localparam int SIDE_W = 11;
  localparam int AREA_W = 21;

  // register indexes
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

endpackage

### design/msq_linebuf.sv
module msq_linebuf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/msq_result.sv
module msq_result
  import msq_pkg::*;
#(
  parameter int SIDE_BITS = SIDE_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_push,
  input  logic [SIDE_BITS-1:0] res_side,
  output logic                 res_rdy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SIDE_W-1:0]    out_max_side,
  output logic [AREA_W-1:0]    out_max_area
);

  logic                   s2_vld_r, s2_vld_nxt;
  logic [SIDE_BITS-1:0]   s2_side_r;
  logic                   out_vld_r, out_vld_nxt;
  logic [SIDE_W-1:0]      out_side_r;
  logic [AREA_W-1:0]      out_area_r;
  logic [2*SIDE_BITS-1:0] prod;
  logic                   out_adv;

  assign out_adv = !out_vld_r || !out_stall;
  assign res_rdy = !s2_vld_r || out_adv;
  assign prod    = (2*SIDE_BITS)'(s2_side_r) * (2*SIDE_BITS)'(s2_side_r);

  always_comb begin
    s2_vld_nxt = s2_vld_r;
    if (res_push) begin
      s2_vld_nxt = 1'b1;
    end else if (out_adv) begin
      s2_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_adv ? s2_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      s2_side_r <= res_side;
    end
    // square the side on its way into the output register
    if (out_adv && s2_vld_r) begin
      out_side_r <= SIDE_W'(s2_side_r);
      out_area_r <= AREA_W'(prod);
    end
  end

  assign out_valid    = out_vld_r;
  assign out_max_side = out_side_r;
  assign out_max_area = out_area_r;

endmodule

### design/maximal_square_dp.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_cell_bit
// out      output     out_valid/out_stall  out_max_side, out_max_area
// cfg      input      cfg_wr_en            cfg_addr, cfg_wdata
//
// One cell per clock. A cell reads the line buffer when accepted and is
// resolved in stage 1, where the size is written back; a same-address
// read behind a write is forwarded. The result of a frame is registered in
// stage 1, the result stage and the output register. The input stalls only
// while a frame-end cell waits behind a full result stage. Reset clears counters and
// the running maximum; the line buffer is not cleared (row 0 ignores what it reads).
module maximal_square_dp
  import msq_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cell_bit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIDE_W-1:0] out_max_side,
  output logic [AREA_W-1:0] out_max_area
);

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MINR = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int SW   = $clog2(MINR + 1);

  logic [CFG_W-1:0] cols_cfg_r, rows_cfg_r;
  logic [CW-1:0]    col_lim;
  logic [RW-1:0]    row_lim;

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             row_end, frame_end, in_accept;

  logic             s1_vld_r, s1_vld_nxt;
  logic             s1_bit_r, s1_first_r, s1_re_r, s1_fe_r, s1_fwd_r;
  logic [CW-1:0]    s1_col_r;
  logic [SW-1:0]    fwd_r;
  logic             s1_go;

  logic [SW-1:0]    rd_data, up, min_ul, min_all, v, best_max;
  logic [SW-1:0]    left_r, upleft_r, best_r;
  logic             res_rdy, res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= CFG_RESET;
      rows_cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_COLS: cols_cfg_r <= cfg_wdata;
        CFG_ROWS: rows_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // last column / row index, saturated into the legal range
  always_comb begin
    if (cols_cfg_r == '0) begin
      col_lim = '0;
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      col_lim = CW'(MAX_COLS - 1);
    end else begin
      col_lim = CW'(cols_cfg_r - CFG_W'(1));
    end
    if (rows_cfg_r == '0) begin
      row_lim = '0;
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      row_lim = RW'(MAX_ROWS - 1);
    end else begin
      row_lim = RW'(rows_cfg_r - CFG_W'(1));
    end
  end

  assign s1_go     = s1_vld_r && (!s1_fe_r || res_rdy);
  assign res_push  = s1_go && s1_fe_r;
  assign in_stall  = s1_vld_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  assign row_end   = (col_r >= col_lim);
  assign frame_end = row_end && (row_r >= row_lim);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    s1_vld_nxt = s1_vld_r;
    if (in_accept) begin
      s1_vld_nxt = 1'b1;
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  msq_linebuf #(
    .DEPTH (MAX_COLS),
    .WIDTH (SW),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (v)
  );

  // resolve the cell in stage 1
  always_comb begin
    up      = s1_fwd_r ? fwd_r : rd_data;
    min_ul  = (up < left_r) ? up : left_r;
    min_all = (min_ul < upleft_r) ? min_ul : upleft_r;
    if (s1_first_r) begin
      v = SW'(s1_bit_r);
    end else if (s1_bit_r) begin
      v = min_all + SW'(1);
    end else begin
      v = '0;
    end
    best_max = (v > best_r) ? v : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      left_r   <= '0;
      upleft_r <= '0;
      best_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= s1_vld_nxt;
      if (s1_go) begin
        if (s1_re_r) begin
          left_r   <= '0;
          upleft_r <= '0;
        end else begin
          left_r   <= v;
          upleft_r <= up;
        end
        best_r <= s1_fe_r ? '0 : best_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bit_r   <= in_cell_bit;
      s1_first_r <= (row_r == '0) || (col_r == '0);
      s1_re_r    <= row_end;
      s1_fe_r    <= frame_end;
      s1_col_r   <= col_r;
      // entry being written this edge: take the new size directly
      s1_fwd_r   <= s1_go && (s1_col_r == col_r);
      fwd_r      <= v;
    end
  end

  msq_result #(
    .SIDE_BITS (SW)
  ) u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_push     (res_push),
    .res_side     (best_max),
    .res_rdy      (res_rdy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_max_side (out_max_side),
    .out_max_area (out_max_area)
  );

`ifndef SYNTH
  a_left_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= best_r)
    else $error("left size exceeds running maximum");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && frame_end |=> (col_r == '0) && (row_r == '0))
    else $error("position not cleared after last cell of frame");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("input stalled with empty resolve stage");
`endif

endmodule

### verif/maximal_square_dp_tb.sv
`timescale 1ns / 1ps

module maximal_square_dp_tb;
  import msq_pkg::*;

  typedef enum {FILL_ONES, FILL_ZEROS, FILL_CHECKER, FILL_RANDOM} fill_t;

  typedef struct {
    logic [SIDE_W-1:0] side;
    logic [AREA_W-1:0] area;
  } square_t;

  typedef struct {
    int    cols;         // -1 leaves the register alone
    int    rows;
    fill_t fill;
    int    resize_at;    // cell count at which to resize, -1 for none
    int    resize_cols;
    int    resize_rows;
    bit    known;        // side and area typed in below
    int    side;
    int    area;
  } frame_spec_t;

  localparam int NUM_DIRECTED       = 15;
  localparam int RANDOM_CELLS       = 860;
  localparam int SETTLE_CYCLES      = 8;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic              cfg_addr    = CFG_COLS;
  logic [CFG_W-1:0]  cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              in_cell_bit = 1'b0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [SIDE_W-1:0] out_max_side;
  logic [AREA_W-1:0] out_max_area;

  maximal_square_dp i_dut (.*);

  // predictor state
  logic [SIDE_W-1:0] row_sizes [DEF_MAX_COLS];
  logic [SIDE_W-1:0] left_sz, diag_sz, best_sz;
  int unsigned       col_pos, row_pos;
  logic [CFG_W-1:0]  cols_reg, rows_reg;

  square_t     expected_squares [$];
  frame_spec_t directed_frames [NUM_DIRECTED];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int cells_sent    = 0;
  int frames_sent   = 0;
  int resizes       = 0;
  int squares_seen  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // One cell through the square-size recurrence; reports the frame result on its last cell.
  task automatic grow_square(input logic b, output bit frame_done, output square_t sq);
    logic [SIDE_W-1:0] up, m, v;
    int unsigned       area;
    bit                row_done;
    up = row_sizes[col_pos];
    if (row_pos == 0 || col_pos == 0) begin
      v = SIDE_W'(b);
    end else if (b) begin
      m = (up < left_sz) ? up : left_sz;
      m = (m < diag_sz) ? m : diag_sz;
      v = m + 1'b1;
    end else begin
      v = '0;
    end
    row_sizes[col_pos] = v;
    diag_sz = up;
    left_sz = v;
    if (v > best_sz) best_sz = v;
    row_done   = (col_pos + 1 >= span(cols_reg, DEF_MAX_COLS));
    frame_done = row_done && (row_pos + 1 >= span(rows_reg, DEF_MAX_ROWS));
    area    = best_sz * best_sz;
    sq.side = best_sz;
    sq.area = area[AREA_W-1:0];
    if (frame_done) begin
      best_sz = '0;
      col_pos = 0;
      row_pos = 0;
      left_sz = '0;
      diag_sz = '0;
    end else if (row_done) begin
      col_pos = 0;
      row_pos++;
      left_sz = '0;
      diag_sz = '0;
    end else begin
      col_pos++;
    end
  endtask

  task automatic write_reg(input logic addr, input int val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    if (addr == CFG_COLS) cols_reg = CFG_W'(val);
    else rows_reg = CFG_W'(val);
  endtask

  // Hold the input until every square is out and the pipeline has emptied.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_sizes(input int cols, input int rows);
    if (cols < 0 && rows < 0) return;
    drain_results();
    if (cols >= 0) write_reg(CFG_COLS, cols);
    if (rows >= 0) write_reg(CFG_ROWS, rows);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_cell(input logic b, output bit frame_done, output square_t sq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cell_bit <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
    grow_square(b, frame_done, sq);
  endtask

  function automatic logic pick_bit(fill_t fill, int ones_pct);
    case (fill)
      FILL_ONES:    return 1'b1;
      FILL_ZEROS:   return 1'b0;
      FILL_CHECKER: return ((row_pos + col_pos) % 2) == 1;
      default:      return $urandom_range(99) < ones_pct;
    endcase
  endfunction

  task automatic run_frame(input frame_spec_t spec, input int ones_pct);
    int      n;
    bit      frame_done;
    square_t sq;
    apply_sizes(spec.cols, spec.rows);
    n = 0;
    frame_done = 1'b0;
    while (!frame_done) begin
      if (n == spec.resize_at) begin
        apply_sizes(spec.resize_cols, spec.resize_rows);
        resizes++;
      end
      send_cell(pick_bit(spec.fill, ones_pct), frame_done, sq);
      n++;
    end
    if (spec.known) begin
      sq.side = SIDE_W'(spec.side);
      sq.area = AREA_W'(spec.area);
    end
    expected_squares.push_back(sq);
    frames_sent++;
  endtask

  always @(posedge clk) begin
    square_t want;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      squares_seen++;
      if (expected_squares.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected beat: side %0d area %0d", out_max_side, out_max_area);
      end else begin
        want = expected_squares.pop_front();
        if (out_max_side !== want.side || out_max_area !== want.area) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: square %0d: expected side %0d area %0d, got side %0d area %0d",
                     squares_seen, want.side, want.area, out_max_side, out_max_area);
        end
      end
    end
  end

  initial begin
    frame_spec_t spec;
    int          ones_pct;
    int          pick;
    int          new_cols, new_rows;
    int          base_cells;

    for (int i = 0; i < DEF_MAX_COLS; i++) row_sizes[i] = '0;
    left_sz  = '0;
    diag_sz  = '0;
    best_sz  = '0;
    col_pos  = 0;
    row_pos  = 0;
    cols_reg = CFG_RESET;
    rows_reg = CFG_RESET;

    directed_frames = '{
      // columns still at reset, a single row cut short by narrowing mid-row
      '{-1,   1,    FILL_ONES,    40, 41, -1, 1'b1, 1,  1},
      '{1,    -1,   FILL_ZEROS,   -1, -1, -1, 1'b1, 0,  0},
      '{-1,   -1,   FILL_ONES,    -1, -1, -1, 1'b1, 1,  1},
      '{4,    4,    FILL_ONES,    -1, -1, -1, 1'b1, 4,  16},
      '{-1,   -1,   FILL_ZEROS,   -1, -1, -1, 1'b1, 0,  0},
      '{5,    3,    FILL_ONES,    -1, -1, -1, 1'b1, 3,  9},
      '{3,    5,    FILL_CHECKER, -1, -1, -1, 1'b1, 1,  1},
      // zero saturates up to one; oversize saturates, then is cut short mid-frame
      '{0,    0,    FILL_ONES,    -1, -1, -1, 1'b1, 1,  1},
      '{2047, 1,    FILL_ONES,    5,  6,  -1, 1'b1, 1,  1},
      '{1,    2047, FILL_ONES,    5,  -1, 6,  1'b1, 1,  1},
      '{16,   16,   FILL_ONES,    -1, -1, -1, 1'b1, 16, 256},
      '{6,    6,    FILL_RANDOM,  -1, -1, -1, 1'b0, 0,  0},
      // narrow right at the end of a row, then past it with fewer rows
      '{8,    4,    FILL_ONES,    10, 3,  3,  1'b0, 0,  0},
      '{8,    4,    FILL_RANDOM,  13, 3,  2,  1'b0, 0,  0},
      '{7,    7,    FILL_RANDOM,  -1, -1, -1, 1'b0, 0,  0}
    };

    send_idle_pct = 8;
    stall_pct     = 57;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_frames[i]) run_frame(directed_frames[i], 75);

    base_cells = cells_sent;
    while (cells_sent - base_cells < RANDOM_CELLS) begin
      if (cells_sent - base_cells < RANDOM_CELLS / 3) begin
        send_idle_pct = 8;
        stall_pct     = 57;
      end else if (cells_sent - base_cells < 2 * RANDOM_CELLS / 3) begin
        send_idle_pct = 57;
        stall_pct     = 8;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end

      spec.cols        = -1;
      spec.rows        = -1;
      spec.resize_at   = -1;
      spec.resize_cols = -1;
      spec.resize_rows = -1;
      spec.known       = 1'b0;
      spec.side        = 0;
      spec.area        = 0;

      pick = $urandom_range(99);
      if (pick < 2) begin
        spec.cols = $urandom_range(2047, 1025);
        spec.rows = 1;
      end else if (pick < 6) begin
        spec.cols = 0;
        spec.rows = $urandom_range(12, 0);
      end else if (pick < 10) begin
        spec.cols = $urandom_range(12, 1);
        spec.rows = 0;
      end else if (pick < 75 || span(cols_reg, DEF_MAX_COLS) > 12) begin
        spec.cols = $urandom_range(12, 1);
        spec.rows = $urandom_range(12, 1);
      end
      // otherwise keep the sizes and run frames back to back

      pick = $urandom_range(99);
      if (pick < 5) spec.fill = FILL_ONES;
      else if (pick < 8) spec.fill = FILL_ZEROS;
      else if (pick < 11) spec.fill = FILL_CHECKER;
      else spec.fill = FILL_RANDOM;
      ones_pct = $urandom_range(98, 40);

      // only ever narrow mid-frame, so no unwritten line buffer entry is read
      if ($urandom_range(99) < 15) begin
        new_cols = (spec.cols >= 0) ? span(CFG_W'(spec.cols), DEF_MAX_COLS)
                                    : span(cols_reg, DEF_MAX_COLS);
        new_rows = (spec.rows >= 0) ? span(CFG_W'(spec.rows), DEF_MAX_ROWS)
                                    : span(rows_reg, DEF_MAX_ROWS);
        if (new_cols * new_rows > 1) begin
          spec.resize_at   = $urandom_range(new_cols * new_rows - 1, 1);
          spec.resize_cols = $urandom_range(new_cols, 1);
          spec.resize_rows = $urandom_range(12, 1);
        end
      end

      // cut an oversize row short early in the row
      if (spec.cols > DEF_MAX_COLS) begin
        spec.resize_at   = $urandom_range(12, 1);
        spec.resize_cols = $urandom_range(12, 1);
        spec.resize_rows = -1;
      end

      run_frame(spec, ones_pct);
    end

    drain_results();

    $display("Streamed %0d cells over %0d frames, %0d of them resized mid-frame.",
             cells_sent, frames_sent, resizes);
    $display("Compared %0d squares under sender and receiver back-pressure, %0d failures.",
             squares_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
